FILE: rtl/key_controlled_stepper_sequencer_top_macros.svh
// Assertion macros used by the stepper sequencer checker.
`ifndef KEY_CONTROLLED_STEPPER_SEQUENCER_TOP_MACROS_SVH
`define KEY_CONTROLLED_STEPPER_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define KCSS_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define KCSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

FILE: rtl/kcss_pkg.sv
// Package: shared types and constants of the stepper sequencer.
`timescale 1ns / 1ps
package kcss_pkg;

   localparam int NUM_KEYS       = 4;
   localparam int HISTORY_LEN    = 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam int KEY_PRESETS    = 3;
   localparam int BEAT_W         = 24;
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;

   typedef logic signed [BEAT_W-1:0] beat_type;
   typedef logic [NUM_KEYS-1:0]      press_type;

   typedef enum logic [1:0] {
      CSR_KEY_ONE   = 2'd0,
      CSR_KEY_TWO   = 2'd1,
      CSR_KEY_THREE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [3:0] COIL_TABLE [8] = '{
      4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
   };

   localparam logic [7:0] LED_RESET = 8'hfe;
   localparam logic [7:0] LED_KEY_ONE   = 8'hfe;
   localparam logic [7:0] LED_KEY_TWO   = 8'hfd;
   localparam logic [7:0] LED_KEY_THREE = 8'hf8;

   localparam beat_type BEATS_ONE_RESET   = 24'sd1222800;
   localparam beat_type BEATS_TWO_RESET   = -24'sd733680;
   localparam beat_type BEATS_THREE_RESET = 24'sd733680;

endpackage

FILE: rtl/key_controlled_stepper_sequencer_top.sv
// Top level of the key controlled stepper sequencer.
//
// One req item per 2 ms tick carries the four raw key levels (1 = released).
// Each item yields exactly one rsp item: coil_drive for this tick's half step,
// the LED byte and the signed beats left after this tick's key actions.
// A key reads as pressed once HISTORY_LEN samples in a row are low.
// Keys 1..3 load beat counts from the csr registers (addresses 0, 4, 8);
// key 4 clears the count. Write csr registers only while no item is in flight.
// A req item passes through the queue, then the back end's result register, to rsp.
// Throughput: one item per cycle while rsp_stall is low; the back end updates
// count, phase and LED byte together for each item.
// A queue of QUEUE_DEPTH entries sits between debounce front and step back;
// while rsp_stall holds, the result holds and the queue fills, then req_stall
// rises. Reset (synchronous) sets histories to released, count and phase to
// zero, LED to 0xfe, csr registers to their preset counts, and empties the
// queue.
`timescale 1ns / 1ps
module key_controlled_stepper_sequencer_top #(
   parameter int HISTORY_LEN = kcss_pkg::HISTORY_LEN,
   parameter int QUEUE_DEPTH = kcss_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kcss_pkg::NUM_KEYS-1:0]   req_key_levels,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [3:0]                      rsp_coil_drive,
   output logic [7:0]                      rsp_led_pattern,
   output logic signed [kcss_pkg::BEAT_W-1:0] rsp_beats_left,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [kcss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kcss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kcss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   kcss_pkg::beat_type     beats_ff [kcss_pkg::KEY_PRESETS];
   kcss_pkg::beat_type     rd_beats;
   kcss_pkg::q_status_type q_status;
   kcss_pkg::press_type    push_press, head_press;
   logic                   push, pop, csr_wr;
   logic [1:0]             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff[0] <= kcss_pkg::BEATS_ONE_RESET;
         beats_ff[1] <= kcss_pkg::BEATS_TWO_RESET;
         beats_ff[2] <= kcss_pkg::BEATS_THREE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            kcss_pkg::CSR_KEY_ONE: begin
               beats_ff[0] <= csr_pwdata[kcss_pkg::BEAT_W-1:0];
            end
            kcss_pkg::CSR_KEY_TWO: begin
               beats_ff[1] <= csr_pwdata[kcss_pkg::BEAT_W-1:0];
            end
            kcss_pkg::CSR_KEY_THREE: begin
               beats_ff[2] <= csr_pwdata[kcss_pkg::BEAT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         kcss_pkg::CSR_KEY_ONE:   rd_beats = beats_ff[0];
         kcss_pkg::CSR_KEY_TWO:   rd_beats = beats_ff[1];
         kcss_pkg::CSR_KEY_THREE: rd_beats = beats_ff[2];
         default:                 rd_beats = '0;
      endcase
      csr_prdata = {{(kcss_pkg::CSR_DATA_W - kcss_pkg::BEAT_W){rd_beats[kcss_pkg::BEAT_W-1]}},
                    rd_beats};
   end

   kcss_front #(
      .HISTORY_LEN(HISTORY_LEN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_levels (req_key_levels),
      .q_status       (q_status),
      .push           (push),
      .push_press     (push_press)
   );

   kcss_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_press (push_press),
      .pop        (pop),
      .head_press (head_press),
      .q_status   (q_status)
   );

   kcss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head_press      (head_press),
      .pop             (pop),
      .key_beats       (beats_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coil_drive  (rsp_coil_drive),
      .rsp_led_pattern (rsp_led_pattern),
      .rsp_beats_left  (rsp_beats_left)
   );

endmodule

FILE: rtl/kcss_front.sv
// Front end: key history shift, debounce and press edge detection.
`timescale 1ns / 1ps
module kcss_front #(
   parameter int HISTORY_LEN = kcss_pkg::HISTORY_LEN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kcss_pkg::NUM_KEYS-1:0] req_key_levels,
   input  kcss_pkg::q_status_type        q_status,
   output logic                          push,
   output kcss_pkg::press_type           push_press
);

   logic [HISTORY_LEN-1:0]        hist_ff [kcss_pkg::NUM_KEYS];
   logic [HISTORY_LEN-1:0]        hist_in [kcss_pkg::NUM_KEYS];
   logic [kcss_pkg::NUM_KEYS-1:0] prev_ff;
   logic [kcss_pkg::NUM_KEYS-1:0] prev_in;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      for (int i = 0; i < kcss_pkg::NUM_KEYS; i++) begin
         hist_in[i]    = {hist_ff[i][HISTORY_LEN-2:0], req_key_levels[i]};
         prev_in[i]    = (hist_in[i] != '0);
         // press: debounced level falls from released to pressed
         push_press[i] = prev_ff[i] && !prev_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kcss_pkg::NUM_KEYS; i++) begin
            hist_ff[i] <= '1;
         end
         prev_ff <= '1;
      end else if (push) begin
         hist_ff <= hist_in;
         prev_ff <= prev_in;
      end
   end

endmodule

FILE: rtl/kcss_queue.sv
// Short queue of press vectors between front and back.
`timescale 1ns / 1ps
module kcss_queue #(
   parameter int DEPTH = kcss_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  kcss_pkg::press_type    push_press,
   input  logic                   pop,
   output kcss_pkg::press_type    head_press,
   output kcss_pkg::q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   kcss_pkg::press_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push, do_pop;

   assign q_status.full  = (count_ff == FULL);
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head_press = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_press;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/kcss_back.sv
// Back end: coil stepping, key actions and the result register.
`timescale 1ns / 1ps
module kcss_back (
   input  logic                   clock,
   input  logic                   reset,
   input  kcss_pkg::q_status_type q_status,
   input  kcss_pkg::press_type    head_press,
   output logic                   pop,
   input  kcss_pkg::beat_type     key_beats [kcss_pkg::KEY_PRESETS],
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_coil_drive,
   output logic [7:0]             rsp_led_pattern,
   output kcss_pkg::beat_type     rsp_beats_left
);

   kcss_pkg::beat_type cnt_ff, cnt_in, cnt_step;
   logic [2:0]         phase_ff, phase_in;
   logic [7:0]         led_ff, led_in;
   logic [3:0]         coil_in;
   logic               rsp_valid_ff;
   logic [3:0]         coil_ff;

   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in = phase_ff;
      cnt_step = cnt_ff;
      coil_in  = 4'h0;
      if (cnt_ff != '0) begin
         if (!cnt_ff[kcss_pkg::BEAT_W-1]) begin
            phase_in = phase_ff + 3'd1;
            cnt_step = cnt_ff - 24'sd1;
         end else begin
            phase_in = phase_ff - 3'd1;
            cnt_step = cnt_ff + 24'sd1;
         end
         coil_in = kcss_pkg::COIL_TABLE[phase_in];
      end
      // key order: later keys override earlier ones
      cnt_in = cnt_step;
      led_in = led_ff;
      if (head_press[0]) begin
         led_in = kcss_pkg::LED_KEY_ONE;
         cnt_in = key_beats[0];
      end
      if (head_press[1]) begin
         led_in = kcss_pkg::LED_KEY_TWO;
         cnt_in = key_beats[1];
      end
      if (head_press[2]) begin
         led_in = kcss_pkg::LED_KEY_THREE;
         cnt_in = key_beats[2];
      end
      if (head_press[3]) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         phase_ff     <= '0;
         led_ff       <= kcss_pkg::LED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cnt_ff       <= cnt_in;
            phase_ff     <= phase_in;
            led_ff       <= led_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         coil_ff <= coil_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coil_drive  = coil_ff;
   assign rsp_led_pattern = led_ff;
   assign rsp_beats_left  = cnt_ff;

endmodule

FILE: rtl/kcss_checker.sv
// Port-level checker for the stepper sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "key_controlled_stepper_sequencer_top_macros.svh"
module kcss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [3:0]                      rsp_coil_drive,
   input logic [7:0]                      rsp_led_pattern,
   input logic [kcss_pkg::BEAT_W-1:0]     rsp_beats_left
);

   // a held result keeps its valid and its payload
   `KCSS_ASSERT_NEXT(rsp_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `KCSS_ASSERT_NEXT(rsp_hold_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_coil_drive) && $stable(rsp_led_pattern) && $stable(rsp_beats_left))
   // reset leaves no result behind
   `KCSS_ASSERT(rst_no_rsp, clock, 1'b0, $past(reset), !rsp_valid)
   // LED byte is always one of the key patterns
   `KCSS_ASSERT(led_legal, clock, reset, rsp_valid, rsp_led_pattern == 8'hfe || rsp_led_pattern == 8'hfd || rsp_led_pattern == 8'hf8)
   // half-step phases drive at most two coils
   `KCSS_ASSERT(coil_legal, clock, reset, rsp_valid, $countones(rsp_coil_drive) <= 2)

endmodule

bind key_controlled_stepper_sequencer_top kcss_checker u_kcss_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_coil_drive  (rsp_coil_drive),
   .rsp_led_pattern (rsp_led_pattern),
   .rsp_beats_left  (rsp_beats_left)
);
